// File: hw/rtl/ksa_pkg.sv
// ----------------------------------------------------------------------------
// ksa_pkg
// Shared types and codes for the keyed slot allocator.
// ----------------------------------------------------------------------------
package ksa_pkg;

    localparam int KEY_W   = 32;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;
    localparam int SLOT_W  = 6;
    localparam int OFFS_W  = 18;
    localparam int CSIZE_W = 13;
    localparam int PROD_W  = SLOT_W + CSIZE_W;

    localparam logic [CSIZE_W-1:0] CSIZE_RESET = 13'd1;

    localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FREE   = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_PRESENT   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [KEY_W-1:0] entity_key;
    } ksa_req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SLOT_W-1:0] slot_index;
        logic [OFFS_W-1:0] byte_offset;
    } ksa_rsp_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic wr_live;
    } ksa_tbl_ctl_t;

    typedef struct packed {
        logic push;
        logic pop;
    } ksa_stk_ctl_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_POP,
        S_ALLOC,
        S_RESP
    } ksa_state_t;

endpackage

// File: hw/rtl/keyed_slot_allocator.sv
// ----------------------------------------------------------------------------
// keyed_slot_allocator
// Maps 32-bit entity keys to storage slots with a LIFO free list.
// ----------------------------------------------------------------------------
//  channel   ports                                    dir   payload
//  request   s_valid / s_ready / s_data               in    ksa_req_t
//  result    m_valid / m_ready / m_data               out   ksa_rsp_t
//  config    cfg_wr_en / cfg_wr_data                  in    component size
//
//  One request at a time. After the accept, the key table is scanned
//  through one comparator until a hit or the last slot, then decide, pop,
//  write and result load follow. After reset a clearing pass resets the
//  live bits; s_ready stays low during it. A held result does not block
//  accepting the next request, but that request waits at its result load
//  until the held result is taken.
// ----------------------------------------------------------------------------
module keyed_slot_allocator #(
    parameter int MAX_SLOTS = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  ksa_pkg::ksa_req_t            s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output ksa_pkg::ksa_rsp_t            m_data,
    input  logic                         cfg_wr_en,
    input  logic [ksa_pkg::CSIZE_W-1:0]  cfg_wr_data
);

    localparam int AW = $clog2(MAX_SLOTS);
    localparam int DW = $clog2(MAX_SLOTS + 1);

    logic [ksa_pkg::CSIZE_W-1:0] csize_reg;
    ksa_pkg::ksa_tbl_ctl_t       tbl_ctl;
    logic [AW-1:0]               tbl_rd_addr;
    logic [AW-1:0]               tbl_wr_addr;
    logic [ksa_pkg::KEY_W-1:0]   tbl_wr_key;
    logic [ksa_pkg::KEY_W-1:0]   tbl_rd_key;
    logic                        tbl_rd_live;
    ksa_pkg::ksa_stk_ctl_t       stk_ctl;
    logic [AW-1:0]               stk_push_slot;
    logic [DW-1:0]               stk_depth;
    logic [AW-1:0]               stk_top;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            csize_reg <= ksa_pkg::CSIZE_RESET;
        end else if (cfg_wr_en) begin
            csize_reg <= cfg_wr_data;
        end
    end

    ksa_table #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_tbl (
        .aclk    (aclk),
        .ctl     (tbl_ctl),
        .rd_addr (tbl_rd_addr),
        .wr_addr (tbl_wr_addr),
        .wr_key  (tbl_wr_key),
        .rd_key  (tbl_rd_key),
        .rd_live (tbl_rd_live)
    );

    ksa_stack #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_stk (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (stk_ctl),
        .push_slot (stk_push_slot),
        .depth     (stk_depth),
        .top_slot  (stk_top)
    );

    ksa_ctrl #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .csize         (csize_reg),
        .tbl_ctl       (tbl_ctl),
        .tbl_rd_addr   (tbl_rd_addr),
        .tbl_wr_addr   (tbl_wr_addr),
        .tbl_wr_key    (tbl_wr_key),
        .tbl_rd_key    (tbl_rd_key),
        .tbl_rd_live   (tbl_rd_live),
        .stk_ctl       (stk_ctl),
        .stk_push_slot (stk_push_slot),
        .stk_depth     (stk_depth),
        .stk_top       (stk_top)
    );

endmodule

// File: hw/rtl/ksa_table.sv
// ----------------------------------------------------------------------------
// ksa_table
// Slot owner keys and live bits, one read port and one write port each.
// ----------------------------------------------------------------------------
module ksa_table #(
    parameter int MAX_SLOTS = 64
) (
    input  logic                          aclk,
    input  ksa_pkg::ksa_tbl_ctl_t         ctl,
    input  logic [$clog2(MAX_SLOTS)-1:0]  rd_addr,
    input  logic [$clog2(MAX_SLOTS)-1:0]  wr_addr,
    input  logic [ksa_pkg::KEY_W-1:0]     wr_key,
    output logic [ksa_pkg::KEY_W-1:0]     rd_key,
    output logic                          rd_live
);

    localparam int AW = $clog2(MAX_SLOTS);

    logic [ksa_pkg::KEY_W-1:0] owner_mem [MAX_SLOTS];
    logic                      live_mem  [MAX_SLOTS];
    logic [ksa_pkg::KEY_W-1:0] rd_key_reg;
    logic                      rd_live_reg;

    // owner key only written on allocate
    always_ff @(posedge aclk) begin
        if (ctl.wr_en && ctl.wr_live) begin
            owner_mem[wr_addr] <= wr_key;
        end
        if (ctl.rd_en) begin
            rd_key_reg <= owner_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            live_mem[wr_addr] <= ctl.wr_live;
        end
        if (ctl.rd_en) begin
            rd_live_reg <= live_mem[rd_addr];
        end
    end

    assign rd_key  = rd_key_reg;
    assign rd_live = rd_live_reg;

endmodule

// File: hw/rtl/ksa_stack.sv
// ----------------------------------------------------------------------------
// ksa_stack
// LIFO of freed slots with its depth counter.
// ----------------------------------------------------------------------------
module ksa_stack #(
    parameter int MAX_SLOTS = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  ksa_pkg::ksa_stk_ctl_t             ctl,
    input  logic [$clog2(MAX_SLOTS)-1:0]      push_slot,
    output logic [$clog2(MAX_SLOTS + 1)-1:0]  depth,
    output logic [$clog2(MAX_SLOTS)-1:0]      top_slot
);

    localparam int AW = $clog2(MAX_SLOTS);
    localparam int DW = $clog2(MAX_SLOTS + 1);

    logic [AW-1:0] stack_mem [MAX_SLOTS];
    logic [DW-1:0] depth_reg;
    logic [DW-1:0] depth_next;
    logic [AW-1:0] top_reg;
    logic [AW-1:0] pop_addr;

    assign pop_addr = AW'(depth_reg - DW'(1));

    always_comb begin
        depth_next = depth_reg;
        if (ctl.push) begin
            depth_next = depth_reg + DW'(1);
        end else if (ctl.pop) begin
            depth_next = depth_reg - DW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg <= '0;
        end else begin
            depth_reg <= depth_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.push) begin
            stack_mem[depth_reg[AW-1:0]] <= push_slot;
        end
        if (ctl.pop) begin
            top_reg <= stack_mem[pop_addr];
        end
    end

    assign depth    = depth_reg;
    assign top_slot = top_reg;

endmodule

// File: hw/rtl/ksa_ctrl.sv
// ----------------------------------------------------------------------------
// ksa_ctrl
// Sequencer: key scan through one shared comparator, update, result register.
// ----------------------------------------------------------------------------
module ksa_ctrl #(
    parameter int MAX_SLOTS = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  ksa_pkg::ksa_req_t                 s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output ksa_pkg::ksa_rsp_t                 m_data,
    input  logic [ksa_pkg::CSIZE_W-1:0]       csize,
    output ksa_pkg::ksa_tbl_ctl_t             tbl_ctl,
    output logic [$clog2(MAX_SLOTS)-1:0]      tbl_rd_addr,
    output logic [$clog2(MAX_SLOTS)-1:0]      tbl_wr_addr,
    output logic [ksa_pkg::KEY_W-1:0]         tbl_wr_key,
    input  logic [ksa_pkg::KEY_W-1:0]         tbl_rd_key,
    input  logic                              tbl_rd_live,
    output ksa_pkg::ksa_stk_ctl_t             stk_ctl,
    output logic [$clog2(MAX_SLOTS)-1:0]      stk_push_slot,
    input  logic [$clog2(MAX_SLOTS + 1)-1:0]  stk_depth,
    input  logic [$clog2(MAX_SLOTS)-1:0]      stk_top
);

    localparam int AW = $clog2(MAX_SLOTS);
    localparam int DW = $clog2(MAX_SLOTS + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_SLOTS - 1);
    localparam logic [DW-1:0] SLOT_CNT  = DW'(MAX_SLOTS);

    ksa_pkg::ksa_state_t state_reg;
    ksa_pkg::ksa_state_t state_next;

    logic [AW-1:0]                 scan_addr_reg;
    logic                          last_issued_reg;
    logic                          cmp_vld_reg;
    logic [AW-1:0]                 cmp_idx_reg;
    logic                          found_reg;
    logic [AW-1:0]                 found_idx_reg;
    logic [AW-1:0]                 pick_reg;
    logic [DW-1:0]                 live_count_reg;
    logic                          m_valid_reg;
    logic [ksa_pkg::CMD_W-1:0]     cmd_reg;
    logic [ksa_pkg::KEY_W-1:0]     key_reg;
    logic [ksa_pkg::STAT_W-1:0]    res_status_reg;
    logic [AW-1:0]                 res_slot_reg;
    ksa_pkg::ksa_rsp_t             m_data_reg;

    logic                          hit;
    logic                          scan_done;
    logic                          is_alloc;
    logic                          is_free;
    logic                          can_pop;
    logic                          can_new;
    logic                          load_rsp;
    logic [ksa_pkg::SLOT_W-1:0]    slot_out;
    logic [ksa_pkg::PROD_W-1:0]    prod;

    assign hit       = cmp_vld_reg && tbl_rd_live && (tbl_rd_key == key_reg);
    assign scan_done = cmp_vld_reg && (cmp_idx_reg == LAST_SLOT);
    assign is_alloc  = (cmd_reg == ksa_pkg::CMD_ALLOC);
    assign is_free   = (cmd_reg == ksa_pkg::CMD_FREE);
    assign can_pop   = (stk_depth != '0) && (stk_depth <= SLOT_CNT);
    assign can_new   = (live_count_reg < SLOT_CNT);
    assign slot_out  = ksa_pkg::SLOT_W'(res_slot_reg);
    assign prod      = ksa_pkg::PROD_W'(slot_out) * ksa_pkg::PROD_W'(csize);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ksa_pkg::S_CLEAR: begin
                if (scan_addr_reg == LAST_SLOT) begin
                    state_next = ksa_pkg::S_IDLE;
                end
            end
            ksa_pkg::S_IDLE: begin
                if (s_valid) begin
                    state_next = ksa_pkg::S_SCAN;
                end
            end
            ksa_pkg::S_SCAN: begin
                if (hit || scan_done) begin
                    state_next = ksa_pkg::S_DECIDE;
                end
            end
            ksa_pkg::S_DECIDE: begin
                priority if (is_alloc && !found_reg && can_pop) begin
                    state_next = ksa_pkg::S_POP;
                end else if (is_alloc && !found_reg && can_new) begin
                    state_next = ksa_pkg::S_ALLOC;
                end else begin
                    state_next = ksa_pkg::S_RESP;
                end
            end
            ksa_pkg::S_POP: begin
                state_next = ksa_pkg::S_ALLOC;
            end
            ksa_pkg::S_ALLOC: begin
                state_next = ksa_pkg::S_RESP;
            end
            ksa_pkg::S_RESP: begin
                if (load_rsp) begin
                    state_next = ksa_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = ksa_pkg::S_CLEAR;
            end
        endcase
    end

    // outputs
    always_comb begin
        s_ready       = 1'b0;
        load_rsp      = 1'b0;
        tbl_ctl       = '0;
        stk_ctl       = '0;
        tbl_wr_addr   = pick_reg;
        unique case (state_reg)
            ksa_pkg::S_CLEAR: begin
                tbl_ctl.wr_en = 1'b1;
                tbl_wr_addr   = scan_addr_reg;
            end
            ksa_pkg::S_IDLE: begin
                s_ready = 1'b1;
            end
            ksa_pkg::S_SCAN: begin
                tbl_ctl.rd_en = !last_issued_reg;
            end
            ksa_pkg::S_DECIDE: begin
                if (is_free && found_reg) begin
                    tbl_ctl.wr_en = 1'b1;
                    tbl_wr_addr   = found_idx_reg;
                    stk_ctl.push  = (stk_depth < SLOT_CNT);
                end
                if (is_alloc && !found_reg && can_pop) begin
                    stk_ctl.pop = 1'b1;
                end
            end
            ksa_pkg::S_POP: begin
            end
            ksa_pkg::S_ALLOC: begin
                tbl_ctl.wr_en   = 1'b1;
                tbl_ctl.wr_live = 1'b1;
            end
            ksa_pkg::S_RESP: begin
                load_rsp = !m_valid_reg || m_ready;
            end
            default: begin
            end
        endcase
    end

    assign tbl_rd_addr   = scan_addr_reg;
    assign tbl_wr_key    = key_reg;
    assign stk_push_slot = found_idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ksa_pkg::S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_addr_reg   <= '0;
            last_issued_reg <= 1'b0;
            cmp_vld_reg     <= 1'b0;
            live_count_reg  <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            cmp_vld_reg <= tbl_ctl.rd_en;
            if (state_reg == ksa_pkg::S_CLEAR || tbl_ctl.rd_en) begin
                scan_addr_reg <= (scan_addr_reg == LAST_SLOT) ? '0
                                                             : scan_addr_reg + AW'(1);
            end
            if (tbl_ctl.rd_en) begin
                last_issued_reg <= (scan_addr_reg == LAST_SLOT);
            end
            if (s_valid && s_ready) begin
                scan_addr_reg   <= '0;
                last_issued_reg <= 1'b0;
            end
            if (state_reg == ksa_pkg::S_DECIDE && is_free && found_reg
                    && live_count_reg != '0) begin
                live_count_reg <= live_count_reg - DW'(1);
            end
            if (state_reg == ksa_pkg::S_ALLOC) begin
                live_count_reg <= live_count_reg + DW'(1);
            end
            m_valid_reg <= load_rsp || (m_valid_reg && !m_ready);
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cmp_idx_reg <= scan_addr_reg;
        if (s_valid && s_ready) begin
            cmd_reg   <= s_data.cmd;
            key_reg   <= s_data.entity_key;
            found_reg <= 1'b0;
        end
        if (state_reg == ksa_pkg::S_SCAN && hit) begin
            found_reg     <= 1'b1;
            found_idx_reg <= cmp_idx_reg;
        end
        if (state_reg == ksa_pkg::S_DECIDE) begin
            if (is_alloc) begin
                res_slot_reg <= '0;
                if (found_reg) begin
                    res_status_reg <= ksa_pkg::STAT_PRESENT;
                end else if (!can_pop && !can_new) begin
                    res_status_reg <= ksa_pkg::STAT_FULL;
                end
                pick_reg <= live_count_reg[AW-1:0];
            end else if (found_reg) begin
                res_status_reg <= ksa_pkg::STAT_OK;
                res_slot_reg   <= found_idx_reg;
            end else begin
                res_status_reg <= ksa_pkg::STAT_NOT_FOUND;
                res_slot_reg   <= '0;
            end
        end
        if (state_reg == ksa_pkg::S_POP) begin
            pick_reg <= stk_top;
        end
        if (state_reg == ksa_pkg::S_ALLOC) begin
            res_status_reg <= ksa_pkg::STAT_OK;
            res_slot_reg   <= pick_reg;
        end
        if (load_rsp) begin
            m_data_reg.status      <= res_status_reg;
            m_data_reg.slot_index  <= slot_out;
            m_data_reg.byte_offset <= prod[ksa_pkg::OFFS_W-1:0];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        load_rsp |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten while held");

    a_slot_budget: assert property (@(posedge aclk) disable iff (!aresetn)
        ((DW+1)'(live_count_reg) + (DW+1)'(stk_depth)) <= (DW+1)'(MAX_SLOTS))
        else $error("live count plus free depth exceeds slot count");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.status != ksa_pkg::STAT_OK)
            |-> (m_data_reg.slot_index == '0 && m_data_reg.byte_offset == '0))
        else $error("error result carries nonzero slot or offset");

    a_accept_scans: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ksa_pkg::S_SCAN && !cmp_vld_reg))
        else $error("accepted request did not start a clean scan");

    a_one_op: assert property (@(posedge aclk) disable iff (!aresetn)
        !(stk_ctl.push && stk_ctl.pop))
        else $error("push and pop in the same cycle");

endmodule
